// ----- design/ljpf_pkg.sv -----
`timescale 1ns / 1ps

package ljpf_pkg;

  // default number of fraction bits for positions, sigma, epsilon and force
  localparam int LJPF_FRAC_BITS = 16;

  // field widths
  localparam int POS_W   = 32;
  localparam int SIG_W   = 24;
  localparam int CUT_W   = 32;
  localparam int FORCE_W = 48;

  // internal widths
  localparam int MAG_W  = 32;
  localparam int SSUM_W = SIG_W + 1;
  localparam int SSQ_W  = 2 * SSUM_W;
  localparam int EPR_W  = 2 * SIG_W;
  localparam int EPS_W  = SIG_W;
  localparam int EPS24_W = EPS_W + 5;
  localparam int R2_W   = 66;
  localparam int DEN_W  = 64;
  localparam int Q_W    = 64;

  // cutoff after reset, integer part
  localparam int CUTOFF_RESET_INT = 3;

  // per item flags carried down the pipeline
  typedef struct packed {
    logic       in_cut;
    logic       coinc;
    logic       wall_a;
    logic       wall_b;
    logic [2:0] neg;
  } ljpf_flags_t;

  // sign of the bracket term and saturation seen before the force division
  typedef struct packed {
    logic gneg;
    logic isat;
  } ljpf_sign_t;

endpackage

// ----- design/ljpf_dly.sv -----
`timescale 1ns / 1ps

module ljpf_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [D];

  // plain shift line
  always_ff @(posedge clk) begin
    sh_r[0] <= din;
    for (int i = 1; i < D; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign dout = sh_r[D-1];

endmodule

// ----- design/ljpf_mul.sv -----
`timescale 1ns / 1ps

module ljpf_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = 32 * (NA + NB);

  logic [32*NA-1:0] a_ext;
  logic [32*NB-1:0] b_ext;
  logic [63:0]      pp_r [NA*NB];
  logic [PW-1:0]    sum_nxt;
  logic [PW-1:0]    sum_r;

  assign a_ext = (32*NA)'(a);
  assign b_ext = (32*NB)'(b);

  // stage one: 32 by 32 partial products
  always_ff @(posedge clk) begin
    for (int ia = 0; ia < NA; ia++) begin
      for (int ib = 0; ib < NB; ib++) begin
        pp_r[ia*NB+ib] <= 64'(a_ext[ia*32 +: 32]) * 64'(b_ext[ib*32 +: 32]);
      end
    end
  end

  // stage two: shifted sum of the partial products
  always_comb begin
    sum_nxt = '0;
    for (int ia = 0; ia < NA; ia++) begin
      for (int ib = 0; ib < NB; ib++) begin
        sum_nxt = sum_nxt + (PW'(pp_r[ia*NB+ib]) << (32 * (ia + ib)));
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign p = sum_r[AW+BW-1:0];

endmodule

// ----- design/ljpf_div.sv -----
`timescale 1ns / 1ps

module ljpf_div #(
  parameter int QW = 64,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_den,
  output logic [QW-1:0] out_quo
);

  // restoring division, one quotient bit per stage; in_rem must be below in_den
  logic [DW-1:0] rem_p [QW];
  logic [QW-1:0] low_p [QW];
  logic [DW-1:0] den_p [QW];
  logic [QW-1:0] quo_p [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  assign rem_p[0] = in_rem;
  assign low_p[0] = in_low;
  assign den_p[0] = in_den;
  assign quo_p[0] = '0;

  for (genvar j = 1; j < QW; j++) begin : g_link
    assign rem_p[j] = rem_r[j-1];
    assign low_p[j] = low_r[j-1];
    assign den_p[j] = den_r[j-1];
    assign quo_p[j] = quo_r[j-1];
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_p[j], low_p[j][QW-1]};
    assign ge    = trial >= {1'b0, den_p[j]};

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? DW'(trial - {1'b0, den_p[j]}) : trial[DW-1:0];
      low_r[j] <= low_p[j] << 1;
      den_r[j] <= den_p[j];
      quo_r[j] <= {quo_p[j][QW-2:0], ge};
    end
  end

  assign out_quo = quo_r[QW-1];

endmodule

// ----- design/ljpf_isqrt.sv -----
`timescale 1ns / 1ps

module ljpf_isqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic [W-1:0]   din,
  output logic [W/2-1:0] root
);

  localparam int RW = W / 2;

  // digit by digit square root, one result bit per stage
  logic [W-1:0] v_p [RW];
  logic [W-1:0] r_p [RW];
  logic [W-1:0] v_r [RW];
  logic [W-1:0] r_r [RW];

  assign v_p[0] = din;
  assign r_p[0] = '0;

  for (genvar j = 1; j < RW; j++) begin : g_link
    assign v_p[j] = v_r[j-1];
    assign r_p[j] = r_r[j-1];
  end

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [W:0] bitv;
    logic [W:0] sum;
    logic       ge;

    assign bitv = (W+1)'(1) << (2 * (RW - 1 - j));
    assign sum  = {1'b0, r_p[j]} + bitv;
    assign ge   = {1'b0, v_p[j]} >= sum;

    always_ff @(posedge clk) begin
      v_r[j] <= ge ? W'({1'b0, v_p[j]} - sum) : v_p[j];
      r_r[j] <= ge ? W'((r_p[j] >> 1) + bitv[W-1:0]) : (r_p[j] >> 1);
    end
  end

  assign root = r_r[RW-1][RW-1:0];

endmodule

// ----- design/lennard_jones_cutoff_pair_force_unit.sv -----
`timescale 1ns / 1ps
// channel | ports                                   | handshake
// input   | in_first_*, in_second_*                 | taken when start high and busy low
// result  | out_force_*, out_within_cutoff .. flags | out_strobe high for one cycle
// config  | cfg_cutoff_radius                       | written when cfg_valid and cfg_ready
//
// one item enters every cycle; busy is always low and cfg_ready always high
// each result passes through the 64-stage sigma^2/r2 divider and the 48-stage force
// divider, with the three 64-bit products for q^2, q^3 and q^6 between
// synchronous active-low reset clears the valid line and sets the cutoff to 3.0
// results cannot be held off, so the pipeline never stalls

module lennard_jones_cutoff_pair_force_unit import ljpf_pkg::*; #(
  parameter int FRAC_BITS = LJPF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [POS_W-1:0]   in_first_pos_x,
  input  logic signed [POS_W-1:0]   in_first_pos_y,
  input  logic signed [POS_W-1:0]   in_first_pos_z,
  input  logic signed [POS_W-1:0]   in_second_pos_x,
  input  logic signed [POS_W-1:0]   in_second_pos_y,
  input  logic signed [POS_W-1:0]   in_second_pos_z,
  input  logic [SIG_W-1:0]          in_first_sigma,
  input  logic [SIG_W-1:0]          in_second_sigma,
  input  logic [SIG_W-1:0]          in_first_epsilon,
  input  logic [SIG_W-1:0]          in_second_epsilon,
  input  logic                      in_first_is_wall,
  input  logic                      in_second_is_wall,
  output logic                      out_strobe,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  output logic signed [FORCE_W-1:0] out_force_z,
  output logic                      out_within_cutoff,
  output logic                      out_apply_to_first,
  output logic                      out_apply_to_second,
  output logic                      out_coincident,
  output logic                      out_saturated,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CUT_W-1:0]          cfg_cutoff_radius
);

  localparam int SHIFT  = 32 - FRAC_BITS;
  localparam int N_W    = 93 + MAG_W;
  localparam int P_W    = EPS24_W + Q_W;
  // cycle at which each value sits in its register
  localparam int T_PRE  = 4;
  localparam int T_Q    = T_PRE + Q_W;
  localparam int T_Q2   = T_Q + 3;
  localparam int T_Q3   = T_Q2 + 3;
  localparam int T_Q6   = T_Q3 + 3;
  localparam int T_TWO  = T_Q6 + 1;
  localparam int T_G    = T_TWO + 1;
  localparam int T_P    = T_G + 2;
  localparam int T_N    = T_P + 2;
  localparam int T_FP   = T_N + 1;
  localparam int T_FD   = T_FP + FORCE_W;
  localparam int T_OUT  = T_FD + 1;
  localparam int T_EPS  = 1 + EPS_W + 1;

  localparam logic [FORCE_W-1:0] LIM_POS = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] LIM_NEG = {1'b1, {(FORCE_W-1){1'b0}}};

  logic acc;
  assign acc       = start & ~busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // cutoff register and its square
  logic [CUT_W-1:0]   cutoff_r;
  logic [2*CUT_W-1:0] cutsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUT_W'(CUTOFF_RESET_INT) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      cutoff_r <= cfg_cutoff_radius;
    end
  end

  always_ff @(posedge clk) begin
    cutsq_r <= (2*CUT_W)'(cutoff_r) * (2*CUT_W)'(cutoff_r);
  end

  // valid line, one bit per stage
  logic [T_OUT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T_OUT-2:0], acc};
    end
  end

  // stage 1: separations, sigma sum, epsilon product
  logic [POS_W-1:0]           pa [3];
  logic [POS_W-1:0]           pb [3];
  logic [2:0][MAG_W-1:0]      mag_nxt;
  logic [2:0]                 neg_nxt;
  logic [2:0][MAG_W-1:0]      mag1_r, mag2_r, mag3_r, mag4_r;
  logic [2:0]                 neg1_r, neg2_r, neg3_r;
  logic [1:0]                 wall1_r, wall2_r, wall3_r;
  logic [SSUM_W-1:0]          ssum1_r;
  logic [EPR_W-1:0]           eprod1_r;

  assign pa[0] = in_first_pos_x;
  assign pa[1] = in_first_pos_y;
  assign pa[2] = in_first_pos_z;
  assign pb[0] = in_second_pos_x;
  assign pb[1] = in_second_pos_y;
  assign pb[2] = in_second_pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [POS_W:0] d;
      d = {pa[i][POS_W-1], pa[i]} - {pb[i][POS_W-1], pb[i]};
      neg_nxt[i] = d[POS_W];
      mag_nxt[i] = d[POS_W] ? MAG_W'(~d + 1'b1) : d[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mag1_r   <= mag_nxt;
    neg1_r   <= neg_nxt;
    wall1_r  <= {in_first_is_wall, in_second_is_wall};
    ssum1_r  <= SSUM_W'(in_first_sigma) + SSUM_W'(in_second_sigma);
    eprod1_r <= EPR_W'(in_first_epsilon) * EPR_W'(in_second_epsilon);
  end

  // stage 2: squares
  logic [2:0][2*MAG_W-1:0] sq2_r;
  logic [SSQ_W-1:0]        ssq2_r, ssq3_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= (2*MAG_W)'(mag1_r[i]) * (2*MAG_W)'(mag1_r[i]);
    end
    ssq2_r  <= SSQ_W'(ssum1_r) * SSQ_W'(ssum1_r);
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    wall2_r <= wall1_r;
  end

  // stage 3: squared distance
  logic [R2_W-1:0] r2_3_r;

  always_ff @(posedge clk) begin
    r2_3_r  <= R2_W'(sq2_r[0]) + R2_W'(sq2_r[1]) + R2_W'(sq2_r[2]);
    ssq3_r  <= ssq2_r;
    mag3_r  <= mag2_r;
    neg3_r  <= neg2_r;
    wall3_r <= wall2_r;
  end

  // stage 4: cutoff test and set-up of the sigma^2 / r2 division
  logic [DEN_W-1:0] qrem_nxt;
  logic [DEN_W-1:0] qrem4_r, qlow4_r, den4_r;
  logic             qsat4_r;
  ljpf_flags_t      flags4_r;

  assign qrem_nxt = DEN_W'(ssq3_r[SSQ_W-1:34]);

  always_ff @(posedge clk) begin
    flags4_r.in_cut <= (r2_3_r[R2_W-1:DEN_W] == '0) && (r2_3_r[DEN_W-1:0] <= cutsq_r);
    flags4_r.coinc  <= (r2_3_r == '0);
    flags4_r.wall_a <= wall3_r[1];
    flags4_r.wall_b <= wall3_r[0];
    flags4_r.neg    <= neg3_r;
    qsat4_r         <= (r2_3_r[DEN_W-1:0] == '0) || (qrem_nxt >= r2_3_r[DEN_W-1:0]);
    qrem4_r         <= qrem_nxt;
    qlow4_r         <= {ssq3_r[33:0], 30'b0};
    den4_r          <= r2_3_r[DEN_W-1:0];
    mag4_r          <= mag3_r;
  end

  // q = sigma^2 / r2 in Q32.32
  logic [Q_W-1:0] q_raw, qv;
  logic           qsat_q;

  ljpf_div #(.QW(Q_W), .DW(DEN_W)) u_qdiv (
    .clk    (clk),
    .in_rem (qrem4_r),
    .in_low (qlow4_r),
    .in_den (den4_r),
    .out_quo(q_raw)
  );

  ljpf_dly #(.W(1), .D(Q_W)) u_dly_qsat (.clk(clk), .din(qsat4_r), .dout(qsat_q));

  assign qv = qsat_q ? '1 : q_raw;

  // q^2, clamped
  logic [2*Q_W-1:0] pr1, pr2, pr3;
  logic [Q_W-1:0]   q2_r, q3_r, q6_r, qd, q3d;
  logic             q2sat_r, q3sat_r, q6sat_r;
  logic             isat_a, isat_b, isat_c;

  ljpf_mul #(.AW(Q_W), .BW(Q_W)) u_mul_q2 (.clk(clk), .a(qv), .b(qv), .p(pr1));

  always_ff @(posedge clk) begin
    q2sat_r <= (pr1[2*Q_W-1:96] != '0);
    q2_r    <= (pr1[2*Q_W-1:96] != '0) ? '1 : pr1[95:32];
  end

  ljpf_dly #(.W(Q_W), .D(3)) u_dly_q (.clk(clk), .din(qv), .dout(qd));
  ljpf_dly #(.W(1), .D(3)) u_dly_is1 (.clk(clk), .din(qsat_q), .dout(isat_a));

  // q^3 = q^2 * q, clamped
  ljpf_mul #(.AW(Q_W), .BW(Q_W)) u_mul_q3 (.clk(clk), .a(q2_r), .b(qd), .p(pr2));

  always_ff @(posedge clk) begin
    q3sat_r <= (pr2[2*Q_W-1:96] != '0);
    q3_r    <= (pr2[2*Q_W-1:96] != '0) ? '1 : pr2[95:32];
  end

  ljpf_dly #(.W(1), .D(3)) u_dly_is2 (
    .clk(clk), .din(isat_a | q2sat_r), .dout(isat_b)
  );

  // q^6 = q^3 * q^3, clamped
  ljpf_mul #(.AW(Q_W), .BW(Q_W)) u_mul_q6 (.clk(clk), .a(q3_r), .b(q3_r), .p(pr3));

  always_ff @(posedge clk) begin
    q6sat_r <= (pr3[2*Q_W-1:96] != '0);
    q6_r    <= (pr3[2*Q_W-1:96] != '0) ? '1 : pr3[95:32];
  end

  ljpf_dly #(.W(Q_W), .D(3)) u_dly_q3 (.clk(clk), .din(q3_r), .dout(q3d));
  ljpf_dly #(.W(1), .D(3)) u_dly_is3 (
    .clk(clk), .din(isat_b | q3sat_r), .dout(isat_c)
  );

  // 2 q^6, clamped
  logic [Q_W-1:0] two6_r, q3t_r, g_r;
  logic           isat7_r, isatg_r, gneg_r;

  always_ff @(posedge clk) begin
    two6_r  <= q6_r[Q_W-1] ? '1 : (q6_r << 1);
    q3t_r   <= q3d;
    isat7_r <= isat_c | q6sat_r | q6_r[Q_W-1];
  end

  // bracket term |2 q^6 - q^3| and its sign
  always_ff @(posedge clk) begin
    gneg_r  <= two6_r < q3t_r;
    g_r     <= (two6_r < q3t_r) ? (q3t_r - two6_r) : (two6_r - q3t_r);
    isatg_r <= isat7_r;
  end

  // mixed epsilon, times 24
  logic [EPS_W-1:0]   eps;
  logic [EPS24_W-1:0] eps24_r, eps24g;

  ljpf_isqrt #(.W(EPR_W)) u_isqrt (.clk(clk), .din(eprod1_r), .root(eps));

  always_ff @(posedge clk) begin
    eps24_r <= (EPS24_W'(eps) << 4) + (EPS24_W'(eps) << 3);
  end

  ljpf_dly #(.W(EPS24_W), .D(T_G - T_EPS)) u_dly_eps (
    .clk(clk), .din(eps24_r), .dout(eps24g)
  );

  // sign and early saturation, carried to the end
  ljpf_sign_t sign_g, sign_fd;

  assign sign_g.gneg = gneg_r;
  assign sign_g.isat = isatg_r & (eps24g != '0);

  ljpf_dly #(.W($bits(ljpf_sign_t)), .D(T_FD - T_G)) u_dly_sign (
    .clk(clk), .din(sign_g), .dout(sign_fd)
  );

  // 24 eps |2q^6 - q^3|
  logic [P_W-1:0] pprod;

  ljpf_mul #(.AW(EPS24_W), .BW(Q_W)) u_mul_p (
    .clk(clk), .a(eps24g), .b(g_r), .p(pprod)
  );

  // separations and r2 brought alongside
  logic [2:0][MAG_W-1:0] magp;
  logic [DEN_W-1:0]      den_n;
  ljpf_flags_t           flags_fd;

  ljpf_dly #(.W(3*MAG_W), .D(T_P - T_PRE)) u_dly_mag (
    .clk(clk), .din(mag4_r), .dout(magp)
  );
  ljpf_dly #(.W(DEN_W), .D(T_N - T_PRE)) u_dly_den (
    .clk(clk), .din(den4_r), .dout(den_n)
  );
  ljpf_dly #(.W($bits(ljpf_flags_t)), .D(T_FD - T_PRE)) u_dly_flags (
    .clk(clk), .din(flags4_r), .dout(flags_fd)
  );

  // per axis: numerator, range check, force division
  logic [2:0][FORCE_W-1:0] fq;
  logic [2:0]              presat_r, presat_fd;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [N_W-1:0]     nprod;
    logic [N_W-1:0]     ns;
    logic [DEN_W-1:0]   frem_r, fden_r;
    logic [FORCE_W-1:0] flow_r;

    ljpf_mul #(.AW(P_W), .BW(MAG_W)) u_mul_n (
      .clk(clk), .a(pprod), .b(magp[i]), .p(nprod)
    );

    assign ns = nprod >> SHIFT;

    // quotient of 2^48 or more always clamps
    always_ff @(posedge clk) begin
      presat_r[i] <= (ns[N_W-1:FORCE_W+DEN_W] != '0)
                  || (ns[FORCE_W+DEN_W-1:FORCE_W] >= den_n);
      frem_r      <= ns[FORCE_W+DEN_W-1:FORCE_W];
      flow_r      <= ns[FORCE_W-1:0];
      fden_r      <= den_n;
    end

    ljpf_div #(.QW(FORCE_W), .DW(DEN_W)) u_fdiv (
      .clk    (clk),
      .in_rem (frem_r),
      .in_low (flow_r),
      .in_den (fden_r),
      .out_quo(fq[i])
    );
  end

  ljpf_dly #(.W(3), .D(FORCE_W)) u_dly_presat (
    .clk(clk), .din(presat_r), .dout(presat_fd)
  );

  // output stage: sign, clamp and masking
  logic [2:0][FORCE_W-1:0] force_nxt;
  logic                    csat_nxt;
  logic                    active;
  logic [2:0][FORCE_W-1:0] force_r;
  logic                    within_r, apply_a_r, apply_b_r, coinc_r, sat_r;

  assign active = flags_fd.in_cut & ~flags_fd.coinc;

  always_comb begin
    csat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      logic               n;
      logic               cl;
      logic [FORCE_W-1:0] lim;
      logic [FORCE_W-1:0] v;
      n   = sign_fd.gneg ^ flags_fd.neg[i];
      lim = n ? LIM_NEG : LIM_POS;
      cl  = presat_fd[i] || (fq[i] > lim);
      v   = cl ? lim : fq[i];
      csat_nxt     = csat_nxt | cl;
      force_nxt[i] = active ? (n ? (~v + 1'b1) : v) : '0;
    end
  end

  always_ff @(posedge clk) begin
    force_r   <= force_nxt;
    within_r  <= flags_fd.in_cut;
    coinc_r   <= flags_fd.coinc;
    apply_a_r <= active & ~flags_fd.wall_a;
    apply_b_r <= active & ~flags_fd.wall_b;
    sat_r     <= active & (csat_nxt | sign_fd.isat);
  end

  assign out_strobe          = vld_r[T_OUT-1];
  assign out_force_x         = force_r[0];
  assign out_force_y         = force_r[1];
  assign out_force_z         = force_r[2];
  assign out_within_cutoff   = within_r;
  assign out_apply_to_first  = apply_a_r;
  assign out_apply_to_second = apply_b_r;
  assign out_coincident      = coinc_r;
  assign out_saturated       = sat_r;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ljpf_pkg::*;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int CALM_TAIL = 150;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic [0:0] {OP_PAIR, OP_CUTOFF} op_kind_e;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [23:0]        sig_a, sig_b, eps_a, eps_b;
    logic               wall_a, wall_b;
  } pair_t;

  typedef struct {
    op_kind_e    kind;
    pair_t       pair;
    logic [31:0] cutoff;
  } op_t;

  typedef struct {
    logic [47:0] fx, fy, fz;
    logic        in_cut, apply_a, apply_b, coinc, sat;
  } force_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  pair_t cur = '0;

  logic out_strobe;
  logic signed [47:0] out_force_x, out_force_y, out_force_z;
  logic out_within_cutoff, out_apply_to_first, out_apply_to_second;
  logic out_coincident, out_saturated;

  op_t           pending_ops[$];
  force_result_t expected_forces[$];
  logic [31:0]   cutoff_model = 32'd196608;
  int            idle_left = 0;
  int            mismatch_count = 0;

  lennard_jones_cutoff_pair_force_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_pos_x(cur.ax), .in_first_pos_y(cur.ay), .in_first_pos_z(cur.az),
    .in_second_pos_x(cur.bx), .in_second_pos_y(cur.by), .in_second_pos_z(cur.bz),
    .in_first_sigma(cur.sig_a), .in_second_sigma(cur.sig_b),
    .in_first_epsilon(cur.eps_a), .in_second_epsilon(cur.eps_b),
    .in_first_is_wall(cur.wall_a), .in_second_is_wall(cur.wall_b),
    .out_strobe(out_strobe),
    .out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
    .out_within_cutoff(out_within_cutoff), .out_apply_to_first(out_apply_to_first),
    .out_apply_to_second(out_apply_to_second), .out_coincident(out_coincident),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_cutoff_radius(cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor square root of the epsilon product
  function automatic logic [63:0] eps_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // q32.32 product, truncated, clamped to all ones
  function automatic logic [63:0] q_product(logic [63:0] a, logic [63:0] b, ref logic sat);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[95:32];
  endfunction

  // expected force for one pair under the given cutoff
  function automatic force_result_t pair_force(pair_t p, logic [31:0] cut);
    force_result_t res;
    longint        d[3];
    logic [127:0]  mag[3];
    logic          neg[3];
    logic [127:0]  r2, cut2, num, quo;
    logic [127:0]  ssum, big_q, n_term;
    logic [63:0]   q, q3, q6, two6, g, eps;
    logic          isat, csat, gneg, n;
    logic [47:0]   v;
    res = '{default: '0};
    isat = 1'b0;
    csat = 1'b0;
    d[0] = longint'(p.ax) - longint'(p.bx);
    d[1] = longint'(p.ay) - longint'(p.by);
    d[2] = longint'(p.az) - longint'(p.bz);
    r2 = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i] < 0;
      mag[i] = neg[i] ? 128'(-d[i]) : 128'(d[i]);
      r2 += mag[i] * mag[i];
    end
    cut2 = {96'd0, cut} * {96'd0, cut};
    res.coinc = (r2 == 0);
    res.in_cut = (r2 <= cut2);
    if (!res.in_cut || res.coinc) return res;

    // mixed sigma squared over r2
    ssum = 128'(p.sig_a) + 128'(p.sig_b);
    big_q = ((ssum * ssum) << 30) / r2;
    if (big_q[127:64] != 0) begin
      isat = 1'b1;
      q = '1;
    end else begin
      q = big_q[63:0];
    end
    q3 = q_product(q_product(q, q, isat), q, isat);
    q6 = q_product(q3, q3, isat);
    if (q6 > 64'h7FFF_FFFF_FFFF_FFFF) begin
      isat = 1'b1;
      two6 = '1;
    end else begin
      two6 = q6 << 1;
    end
    gneg = two6 < q3;
    g = gneg ? q3 - two6 : two6 - q3;
    eps = eps_root({40'd0, p.eps_a} * {40'd0, p.eps_b});
    if (eps == 0) isat = 1'b0;
    n_term = 128'(eps * 64'd24) * {64'd0, g};

    // per axis magnitude, clamp, then sign
    for (int i = 0; i < 3; i++) begin
      n = gneg != neg[i];
      num = (n_term * mag[i]) >> (32 - LJPF_FRAC_BITS);
      quo = num / r2;
      if (n && quo > 128'h8000_0000_0000) begin
        csat = 1'b1;
        quo = 128'h8000_0000_0000;
      end else if (!n && quo > 128'h7FFF_FFFF_FFFF) begin
        csat = 1'b1;
        quo = 128'h7FFF_FFFF_FFFF;
      end
      v = n ? -quo[47:0] : quo[47:0];
      if (i == 0) res.fx = v;
      else if (i == 1) res.fy = v;
      else res.fz = v;
    end
    res.apply_a = !p.wall_a;
    res.apply_b = !p.wall_b;
    res.sat = isat || csat;
    return res;
  endfunction

  // driver: one item or one cutoff write per handshake
  always @(posedge clk) begin
    logic  n_start;
    logic  n_cfg;
    op_t   head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (start && !busy) expected_forces.push_back(pair_force(cur, cutoff_model));
      if (cfg_valid && cfg_ready) cutoff_model = cfg_data;
      if (!((start && busy) || (cfg_valid && !cfg_ready))) begin
        n_start = 1'b0;
        n_cfg = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_ops.size() > 0) begin
          head = pending_ops[0];
          if (head.kind == OP_PAIR) begin
            if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
              idle_left = $urandom_range(1, 17);
            end else begin
              void'(pending_ops.pop_front());
              cur <= head.pair;
              n_start = 1'b1;
            end
          end else if (expected_forces.size() == 0 && !start) begin
            // cutoff changes only once the pipeline has emptied
            void'(pending_ops.pop_front());
            cfg_data <= head.cutoff;
            n_cfg = 1'b1;
          end
        end
        start <= n_start;
        cfg_valid <= n_cfg;
      end
    end
  end

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    force_result_t e;
    if (rst_n && out_strobe) begin
      if (expected_forces.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result expected none actual fx=%h", $time, out_force_x);
      end else begin
        e = expected_forces.pop_front();
        check_field("force_x", e.fx, out_force_x);
        check_field("force_y", e.fy, out_force_y);
        check_field("force_z", e.fz, out_force_z);
        check_field("within_cutoff", 48'(e.in_cut), 48'(out_within_cutoff));
        check_field("apply_to_first", 48'(e.apply_a), 48'(out_apply_to_first));
        check_field("apply_to_second", 48'(e.apply_b), 48'(out_apply_to_second));
        check_field("coincident", 48'(e.coinc), 48'(out_coincident));
        check_field("saturated", 48'(e.sat), 48'(out_saturated));
      end
    end
  end

  function automatic op_t mk_pair(logic [31:0] ax, ay, az, bx, by, bz,
                                  logic [23:0] sa, sb, ea, eb, logic wa, wb);
    op_t o;
    o.kind = OP_PAIR;
    o.cutoff = '0;
    o.pair = '{ax, ay, az, bx, by, bz, sa, sb, ea, eb, wa, wb};
    return o;
  endfunction

  function automatic op_t mk_cutoff(logic [31:0] c);
    op_t o;
    o.kind = OP_CUTOFF;
    o.pair = '0;
    o.cutoff = c;
    return o;
  endfunction

  // random pair, mostly close neighbours, some anywhere
  function automatic op_t rand_pair();
    logic [31:0] base[3];
    logic [31:0] off[3];
    int          sh;
    op_t         o;
    for (int i = 0; i < 3; i++) base[i] = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      o = mk_pair(base[0], base[1], base[2], $urandom, $urandom, $urandom,
                  24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  1'($urandom), 1'($urandom));
    end else begin
      for (int i = 0; i < 3; i++) begin
        sh = $urandom_range(4, 18);
        off[i] = $urandom_range(0, (1 << sh) - 1) - (1 << (sh - 1));
      end
      o = mk_pair(base[0], base[1], base[2],
                  base[0] - off[0], base[1] - off[1], base[2] - off[2],
                  24'($urandom_range(0, 3 * ONE)), 24'($urandom_range(0, 3 * ONE)),
                  24'($urandom_range(0, 4 * ONE)), 24'($urandom_range(0, 4 * ONE)),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    end
    return o;
  endfunction

  // stimulus and end of run
  initial begin
    logic [31:0] cutoffs[8];
    logic [31:0] s1, e1;
    s1 = ONE[23:0];
    e1 = ONE[23:0];
    cutoffs = '{32'd196608, 32'd0, 32'hFFFF_FFFF, ONE, 32'h0002_8000, 32'h0000_0100,
                32'h7FFF_0000, 32'd196608};

    // directed pairs under the reset cutoff
    pending_ops.push_back(mk_pair(0, 0, 0, 0, 0, 0, s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(ONE, 0, 0, 0, 0, 0, s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(3 * ONE, 0, 0, 0, 0, 0, s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(3 * ONE + 1, 0, 0, 0, 0, 0, s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  '1, '1, '1, '1, 1, 1));
    pending_ops.push_back(mk_pair(1, 0, 0, 0, 0, 0, '1, '1, '1, '1, 0, 0));
    pending_ops.push_back(mk_pair(1, 0, 0, 0, 0, 0, '1, '1, 0, '1, 0, 0));
    pending_ops.push_back(mk_pair(0, 0, 1, 0, 0, 0, s1, s1, e1, 0, 0, 0));
    pending_ops.push_back(mk_pair(ONE, ONE, 0, 0, 0, 0, s1, s1, e1, e1, 1, 0));
    pending_ops.push_back(mk_pair(ONE, 0, ONE, 0, 0, 0, s1, s1, e1, e1, 0, 1));
    pending_ops.push_back(mk_pair(0, ONE, ONE, 0, 0, 0, s1, s1, e1, e1, 1, 1));
    pending_ops.push_back(mk_pair(-32'sd72090, 32'sd32768, -32'sd19660, 0, 0, 0,
                                  s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(2 * ONE, 0, 0, 0, 0, 0, '1, '1, '1, '1, 0, 0));
    pending_ops.push_back(mk_pair(0, 2 * ONE, 0, 0, 0, 0, s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(0, 0, ONE, 0, 0, 0, 0, 0, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(32'h7FFF_FFFF, 0, 0, 32'h7FFE_0000, 0, 0,
                                  s1, s1, e1, e1, 0, 0));
    pending_ops.push_back(mk_pair(0, 0, 0, ONE, 0, 0, s1, 2 * s1, e1, 4 * e1, 0, 0));

    // random phases; every phase but the first starts with its own cutoff write
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) pending_ops.push_back(mk_cutoff(cutoffs[ph]));
      for (int k = 0; k < 141; k++) pending_ops.push_back(rand_pair());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_ops.size() != 0 || start || cfg_valid || expected_forces.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_forces.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ljpf_pkg.sv
design/ljpf_dly.sv
design/ljpf_mul.sv
design/ljpf_div.sv
design/ljpf_isqrt.sv
design/lennard_jones_cutoff_pair_force_unit.sv
tb/testbench.sv
